// File: hw/rtl/pefhd_pkg.sv
// pefhd_pkg: constants, types and the code-to-nibble table for the frame header decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package pefhd_pkg;

	// frame layout
	localparam int CODE_STRIDE = 6;
	localparam int HDR_LEN     = 13;
	localparam int LOW_OFFSET  = 3;
	localparam int FINAL_POS   = CODE_STRIDE * (HDR_LEN - 1) + LOW_OFFSET;
	localparam int POS_W       = $clog2(FINAL_POS + 1);

	// nibble codes
	localparam logic [7:0] CODE_BASE  = 8'h82;
	localparam logic [7:0] CODE_LIMIT = 8'h94;

	// marker words
	localparam logic [15:0] HEAD_WORD = 16'h5a5b;
	localparam logic [15:0] TAIL_WORD = 16'h5b5a;

	// configuration
	localparam int                PADDR_W        = 3;
	localparam logic [7:0]        TYPE_LIMIT_RST = 8'd8;
	localparam logic [0:0]        REG_TYPE_LIMIT = 1'b0;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_CODE  = 3'd1,
		ST_BAD_MARK  = 3'd2,
		ST_BAD_TYPE  = 3'd3,
		ST_TOO_SHORT = 3'd4
	} status_t;

	// header state handed from the assembly stage to the result stage
	typedef struct packed {
		logic        fire;
		logic        short_frame;
		logic        code_err;
		logic        marks_ok;
		logic [7:0]  channel;
		logic [31:0] frame_number;
		logic [7:0]  frame_type;
	} hdr_info_t;

	// code offset to nibble, two codes map twice
	function automatic logic [3:0] nibble_of(input logic [4:0] idx);
		logic [3:0] n;
		case (idx)
			5'd0:  n = 4'd0;
			5'd1:  n = 4'd1;
			5'd2:  n = 4'd2;
			5'd3:  n = 4'd3;
			5'd4:  n = 4'd4;
			5'd5:  n = 4'd4;
			5'd6:  n = 4'd5;
			5'd7:  n = 4'd6;
			5'd8:  n = 4'd7;
			5'd9:  n = 4'd8;
			5'd10: n = 4'd9;
			5'd11: n = 4'd10;
			5'd12: n = 4'd10;
			5'd13: n = 4'd11;
			5'd14: n = 4'd12;
			5'd15: n = 4'd13;
			5'd16: n = 4'd14;
			5'd17: n = 4'd15;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pefhd_apb_regs.sv
// pefhd_apb_regs: apb-style register port holding the frame type limit
// depends on pefhd_pkg
`default_nettype none

module pefhd_apb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pefhd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output logic      [7:0]                    type_limit
);
	import pefhd_pkg::*;

	logic [7:0] type_limit_q;
	logic       reg_hit;

	// word index is paddr above the byte lanes
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_TYPE_LIMIT);
	assign pready  = 1'b1;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_limit_q <= TYPE_LIMIT_RST;
		end else if (psel && penable && pwrite && reg_hit) begin
			type_limit_q <= pwdata[7:0];
		end
	end

	// read back
	assign prdata     = reg_hit ? {24'd0, type_limit_q} : 32'd0;
	assign type_limit = type_limit_q;

endmodule

`default_nettype wire

// File: hw/rtl/pefhd_header.sv
// pefhd_header: input register, byte position tracking and header byte assembly
// depends on pefhd_pkg
`default_nettype none

module pefhd_header (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 last_byte,
	output logic                      in_stall,
	input  wire logic                 advance,
	output pefhd_pkg::hdr_info_t      info
);
	import pefhd_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	logic [POS_W-1:0] pos_q;
	logic             err_q;
	logic             given_q;
	logic [7:0]       hdr_q  [HDR_LEN];
	logic [7:0]       hdr_nx [HDR_LEN];

	logic             step;
	logic             active;
	logic             at_final;
	logic             code_ok;
	logic [3:0]       nib;
	logic             any_hit;
	logic             err_nx;

	// input register, holds while the result side is blocked
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;
	assign active   = step && !given_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// code decode, an out-of-range code gives a zero nibble
	assign code_ok  = (byte_s1 >= CODE_BASE) && (byte_s1 < CODE_LIMIT);
	assign nib      = code_ok ? nibble_of(5'(byte_s1 - CODE_BASE)) : 4'd0;
	assign at_final = (pos_q == POS_W'(FINAL_POS));

	// place the nibble into the header entry whose code offset matches
	always_comb begin
		any_hit = 1'b0;
		for (int i = 0; i < HDR_LEN; i++) begin
			hdr_nx[i] = hdr_q[i];
			if (pos_q == POS_W'(CODE_STRIDE * i)) begin
				hdr_nx[i] = {nib, 4'd0};
				any_hit   = 1'b1;
			end
			if (pos_q == POS_W'(CODE_STRIDE * i + LOW_OFFSET)) begin
				hdr_nx[i] = {hdr_q[i][7:4], nib};
				any_hit   = 1'b1;
			end
		end
	end

	assign err_nx = err_q || (any_hit && !code_ok);

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			err_q   <= 1'b0;
			given_q <= 1'b0;
		end else if (step) begin
			if (last_s1) begin
				pos_q   <= '0;
				err_q   <= 1'b0;
				given_q <= 1'b0;
			end else if (!given_q) begin
				err_q <= err_nx;
				if (at_final) begin
					given_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// header store, entries are written before they are read
	always_ff @(posedge clk) begin
		if (active) begin
			for (int i = 0; i < HDR_LEN; i++) begin
				hdr_q[i] <= hdr_nx[i];
			end
		end
	end

	// header view for the result stage, including this byte's nibble
	always_comb begin
		info.fire         = active && at_final;
		info.short_frame  = active && last_s1 && !at_final;
		info.code_err     = err_nx;
		info.marks_ok     = ({hdr_nx[1], hdr_nx[0]} == HEAD_WORD) &&
		                    ({hdr_nx[12], hdr_nx[11]} == TAIL_WORD);
		info.channel      = hdr_nx[2];
		info.frame_number = {hdr_nx[6], hdr_nx[5], hdr_nx[4], hdr_nx[3]};
		info.frame_type   = hdr_nx[7];
	end

endmodule

`default_nettype wire

// File: hw/rtl/pefhd_result.sv
// pefhd_result: status evaluation and the output register with its stall control
// depends on pefhd_pkg
`default_nettype none

module pefhd_result (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pefhd_pkg::hdr_info_t info,
	input  wire logic [7:0]           type_limit,
	output logic                      advance,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [2:0]                status,
	output logic [7:0]                channel,
	output logic [31:0]               frame_number,
	output logic [7:0]                frame_type
);
	import pefhd_pkg::*;

	logic        out_valid_q;
	status_t     status_q;
	logic [7:0]  channel_q;
	logic [31:0] frame_number_q;
	logic [7:0]  frame_type_q;
	status_t     status_nx;

	// the pipe moves whenever the output register is free or being drained
	assign advance = !out_valid_q || !out_stall;

	// status priority: short frame, code, marker words, type
	always_comb begin
		if (info.short_frame) begin
			status_nx = ST_TOO_SHORT;
		end else if (info.code_err) begin
			status_nx = ST_BAD_CODE;
		end else if (!info.marks_ok) begin
			status_nx = ST_BAD_MARK;
		end else if (info.frame_type >= type_limit) begin
			status_nx = ST_BAD_TYPE;
		end else begin
			status_nx = ST_OK;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= info.fire || info.short_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_nx;
			if (status_nx == ST_OK) begin
				channel_q      <= info.channel;
				frame_number_q <= info.frame_number;
				frame_type_q   <= info.frame_type;
			end else begin
				channel_q      <= 8'd0;
				frame_number_q <= 32'd0;
				frame_type_q   <= 8'd0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign channel      = channel_q;
	assign frame_number = frame_number_q;
	assign frame_type   = frame_type_q;

endmodule

`default_nettype wire

// File: hw/rtl/pixel_embedded_frame_header_decoder_core.sv
// pixel_embedded_frame_header_decoder_core: top level of the embedded frame header decoder
// depends on pefhd_pkg, pefhd_apb_regs, pefhd_header, pefhd_result
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_stall   data_byte, last_byte
//  out       source     out_valid / out_stall status, channel, frame_number, frame_type
//  apb       slave      psel/penable/pready   paddr, pwdata, prdata (type_limit at 0x0)
//
// one item per cycle while out_stall is low: an input register feeds the header assembly,
// whose result goes straight into the output register, so an item passes both registers.
// arst_n clears the frame position, error and result flags and both valid bits;
// type_limit resets to 8. out_stall holds a valid output register; an empty input register
// still takes one more item, then in_stall rises until the output drains.
`default_nettype none

module pixel_embedded_frame_header_decoder_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          last_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [2:0]                    status,
	output logic      [7:0]                    channel,
	output logic      [31:0]                   frame_number,
	output logic      [7:0]                    frame_type,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pefhd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);
	import pefhd_pkg::*;

	logic       advance;
	logic [7:0] type_limit;
	hdr_info_t  info;

	// configuration registers
	pefhd_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.type_limit (type_limit)
	);

	// header assembly
	pefhd_header u_header (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.in_stall  (in_stall),
		.advance   (advance),
		.info      (info)
	);

	// status and output register
	pefhd_result u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.info         (info),
		.type_limit   (type_limit),
		.advance      (advance),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.channel      (channel),
		.frame_number (frame_number),
		.frame_type   (frame_type)
	);

endmodule

`default_nettype wire

// File: tb/pixel_embedded_frame_header_decoder_core_test.sv
// testbench for pixel_embedded_frame_header_decoder_core: frames of bytes in, one decoded header result out
// depends on pefhd_pkg and the decoder rtl; self-checking against its own header decoder prediction

module pixel_embedded_frame_header_decoder_core_test;
	import pefhd_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 400;
	localparam int CODE_SPAN     = CODE_LIMIT - CODE_BASE;
	localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * REG_TYPE_LIMIT);

	// nibble carried by each code, counted from the lowest legal code
	localparam logic [3:0] NIBBLE_OF_CODE [0:17] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd7,
		4'd8, 4'd9, 4'd10, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
	};

	typedef logic [HDR_LEN-1:0][7:0] header_bytes_t;

	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic [6:0] gap_odds;
	} frame_byte_t;

	typedef struct {
		status_t     st;
		logic [7:0]  chan;
		logic [31:0] fnum;
		logic [7:0]  ftype;
	} header_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [7:0]  channel;
	logic [31:0] frame_number;
	logic [7:0]  frame_type;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// frame bytes waiting to be driven, decoded headers waiting to come out
	frame_byte_t    frame_bytes[$];
	header_result_t decoded_headers[$];

	// predicted decoder state
	int unsigned   frame_pos      = 0;
	header_bytes_t hdr_bytes      = '0;
	bit            code_fault     = 0;
	bit            frame_reported = 0;
	logic [7:0]    type_ceiling   = TYPE_LIMIT_RST;

	// stimulus bookkeeping
	int          mismatches    = 0;
	int unsigned bytes_queued  = 0;
	int unsigned frames_queued = 0;
	logic [6:0]  tx_odds       = 0;
	int unsigned tx_gap        = 0;
	bit          byte_taken    = 0;
	bit          idling_on     = 1;
	bit          long_hold_req = 0;
	int unsigned hold_left     = 0;
	int unsigned rx_burst      = 0;
	int unsigned rx_cycles     = 0;
	int unsigned rx_odds       = 0;

	pixel_embedded_frame_header_decoder_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.channel      (channel),
		.frame_number (frame_number),
		.frame_type   (frame_type),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		out_stall = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// out-of-range codes flag the frame and read as a zero nibble
	function automatic logic [3:0] nibble_from_code(input logic [7:0] code);
		if (code < CODE_BASE || code >= CODE_LIMIT) begin
			code_fault = 1'b1;
			return 4'h0;
		end
		return NIBBLE_OF_CODE[code - CODE_BASE];
	endfunction

	// advance the decoder state by one frame byte, queueing any header result
	task automatic decode_frame_byte(input logic [7:0] b, input logic fin);
		int unsigned    p;
		header_result_t r;
		p = frame_pos;
		r.st    = ST_OK;
		r.chan  = '0;
		r.fnum  = '0;
		r.ftype = '0;
		if (!frame_reported) begin
			if (p % CODE_STRIDE == 0 && p / CODE_STRIDE < HDR_LEN)
				hdr_bytes[p / CODE_STRIDE] = {nibble_from_code(b), 4'h0};
			if (p >= LOW_OFFSET && (p - LOW_OFFSET) % CODE_STRIDE == 0 &&
			    (p - LOW_OFFSET) / CODE_STRIDE < HDR_LEN)
				hdr_bytes[(p - LOW_OFFSET) / CODE_STRIDE][3:0] = nibble_from_code(b);
			if (p == FINAL_POS) begin
				if (code_fault) begin
					r.st = ST_BAD_CODE;
				end else if (hdr_bytes[1:0] != HEAD_WORD || hdr_bytes[12:11] != TAIL_WORD) begin
					r.st = ST_BAD_MARK;
				end else if (hdr_bytes[7] >= type_ceiling) begin
					r.st = ST_BAD_TYPE;
				end else begin
					r.chan  = hdr_bytes[2];
					r.fnum  = hdr_bytes[6:3];
					r.ftype = hdr_bytes[7];
				end
				decoded_headers.push_back(r);
				frame_reported = 1'b1;
			end else begin
				frame_pos = p + 1;
			end
		end
		if (fin) begin
			if (!frame_reported) begin
				r.st = ST_TOO_SHORT;
				decoded_headers.push_back(r);
			end
			frame_pos      = 0;
			code_fault     = 1'b0;
			frame_reported = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// legal code for a nibble, either of the two where a nibble has two
	function automatic logic [7:0] code_for(input logic [3:0] n);
		logic [7:0] c;
		c = 8'h00;
		for (int k = 0; k < CODE_SPAN; k++)
			if (NIBBLE_OF_CODE[k] == n && (c == 8'h00 || $urandom_range(0, 1) == 1))
				c = CODE_BASE + 8'(k);
		return c;
	endfunction

	// illegal code, often right at the edges of the legal range
	function automatic logic [7:0] stray_code();
		case ($urandom_range(0, 3))
			0: return CODE_BASE - 8'd1;
			1: return CODE_LIMIT;
			2: return 8'($urandom_range(0, CODE_BASE - 1));
			default: return 8'($urandom_range(CODE_LIMIT, 255));
		endcase
	endfunction

	function automatic header_bytes_t build_header(input logic [7:0] chan, input logic [31:0] fnum,
		input logic [7:0] ftype);
		header_bytes_t h;
		h[1:0]   = HEAD_WORD;
		h[2]     = chan;
		h[6:3]   = fnum;
		h[7]     = ftype;
		h[10:8]  = 24'($urandom);
		h[12:11] = TAIL_WORD;
		return h;
	endfunction

	// spread a header over a frame of len bytes; bad_slot picks one code to corrupt
	// (twice the header byte index, plus one for the low nibble), -1 for none
	task automatic queue_frame(input header_bytes_t h, input int unsigned len, input int bad_slot);
		int          slot;
		frame_byte_t nb;
		for (int unsigned p = 0; p < len; p++) begin
			nb.b = 8'($urandom);
			slot = -1;
			if (p % CODE_STRIDE == 0 && p / CODE_STRIDE < HDR_LEN) begin
				slot = 2 * (p / CODE_STRIDE);
				nb.b = code_for(h[p / CODE_STRIDE][7:4]);
			end else if (p >= LOW_OFFSET && (p - LOW_OFFSET) % CODE_STRIDE == 0 &&
			             (p - LOW_OFFSET) / CODE_STRIDE < HDR_LEN) begin
				slot = 2 * ((p - LOW_OFFSET) / CODE_STRIDE) + 1;
				nb.b = code_for(h[(p - LOW_OFFSET) / CODE_STRIDE][3:0]);
			end
			if (slot >= 0 && slot == bad_slot)
				nb.b = stray_code();
			nb.fin      = (p == len - 1);
			nb.gap_odds = tx_odds;
			frame_bytes.push_back(nb);
		end
		bytes_queued += len;
		frames_queued++;
	endtask

	// mostly well-formed frames, plus broken markers, bad codes, short frames and noise
	task automatic random_frames(input int unsigned min_bytes, input int unsigned min_frames);
		int unsigned   b0;
		int unsigned   f0;
		int unsigned   kind;
		int unsigned   len;
		int unsigned   k;
		int            bad;
		logic [7:0]    ft;
		header_bytes_t h;
		frame_byte_t   nb;
		b0 = bytes_queued;
		f0 = frames_queued;
		while (bytes_queued - b0 < min_bytes || frames_queued - f0 < min_frames) begin
			tx_odds = (!idling_on || $urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom_range(5, 40));
			case ($urandom_range(0, 3))
				0: ft = 8'($urandom_range(0, type_ceiling - 1));
				1: ft = type_ceiling;
				2: ft = type_ceiling - 8'd1;
				default: ft = 8'($urandom);
			endcase
			h   = build_header(8'($urandom), $urandom, ft);
			len = FINAL_POS + 1 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8));
			bad = -1;
			kind = $urandom_range(0, 99);
			if (kind >= 55 && kind < 65) begin
				// one bit off in the head or tail word
				k = $urandom_range(0, 3);
				k = (k < 2) ? k : k + 9;
				h[k] ^= 8'(1 << $urandom_range(0, 7));
			end else if (kind >= 65 && kind < 73) begin
				bad = $urandom_range(0, 2 * HDR_LEN - 1);
				if ($urandom_range(0, 1) == 1)
					h[0] ^= 8'h01;
			end else if (kind >= 73 && kind < 93) begin
				len = $urandom_range(1, FINAL_POS);
			end
			if (kind >= 93) begin
				len = $urandom_range(1, 100);
				for (int unsigned p = 0; p < len; p++) begin
					nb.b        = 8'($urandom);
					nb.fin      = (p == len - 1);
					nb.gap_odds = tx_odds;
					frame_bytes.push_back(nb);
				end
				bytes_queued += len;
				frames_queued++;
			end else begin
				queue_frame(h, len, bad);
			end
		end
	endtask

	// wait for the decoder to empty, with room for trailing bytes still in flight
	task automatic wait_drained();
		while (frame_bytes.size() != 0 || in_valid || decoded_headers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write then read-back, only while the decoder is idle
	task automatic write_type_limit(input logic [7:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= LIMIT_ADDR;
		pwdata  <= {24'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		type_ceiling = value;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("type_limit", {24'h0, value}, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// driver: next frame byte after a handshake, with random gaps
	always @(negedge clk) begin
		frame_byte_t nb;
		logic        next_valid;
		if (arst_n) begin
			if (!in_valid || byte_taken) begin
				byte_taken = 1'b0;
				next_valid = 1'b0;
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (frame_bytes.size() > 0) begin
					nb = frame_bytes.pop_front();
					next_valid = 1'b1;
					data_byte <= nb.b;
					last_byte <= nb.fin;
					if ($urandom_range(0, 99) < nb.gap_odds)
						tx_gap = $urandom_range(1, 10);
				end
				in_valid <= next_valid;
			end
		end
	end

	// receiver stall: random bursts, quiet stretches and the long hold-off
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left     = LONG_HOLD;
		end
		if (rx_cycles == 0) begin
			rx_cycles = $urandom_range(50, 150);
			rx_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
		end
		rx_cycles--;
		if (!idling_on) begin
			rx_odds  = 0;
			rx_burst = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (rx_burst > 0) begin
			rx_burst--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < rx_odds) begin
			rx_burst = $urandom_range(0, 9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor: check results, then predict from the byte taken at this edge
	always @(posedge clk) begin
		header_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (decoded_headers.size() == 0) begin
					$error("result with nothing expected: status %0d", status);
					mismatches++;
				end else begin
					want = decoded_headers.pop_front();
					check_field("status", want.st, status);
					check_field("channel", want.chan, channel);
					check_field("frame_number", want.fnum, frame_number);
					check_field("frame_type", want.ftype, frame_type);
				end
			end
			if (in_valid && !in_stall) begin
				decode_frame_byte(data_byte, last_byte);
				byte_taken = 1'b1;
			end
		end
	end

	// stimulus phases
	initial begin
		header_bytes_t h;
		@(posedge arst_n);
		tx_odds = 7'd20;

		// directed frames at the reset type limit
		queue_frame(build_header(8'h00, 32'h0, 8'h00), 1, -1);
		queue_frame(build_header(8'hFF, 32'hFFFF_FFFF, type_ceiling - 8'd1), FINAL_POS + 1, -1);
		queue_frame(build_header(8'h00, 32'h0, 8'h00), FINAL_POS + 5, -1);
		queue_frame(build_header(8'h5A, 32'h1234_5678, type_ceiling), FINAL_POS + 1, -1);
		// bad code together with a bad head word: the code error wins
		h = build_header(8'h01, 32'h1, 8'h01);
		h[0] ^= 8'h01;
		queue_frame(h, FINAL_POS + 1, 0);
		// bad code on the very last low-nibble code
		queue_frame(build_header(8'h02, 32'h2, 8'h02), FINAL_POS + 1, 2 * HDR_LEN - 1);
		// bad tail word together with a bad type: the marker error wins
		h = build_header(8'h03, 32'h3, 8'hFF);
		h[12] ^= 8'h80;
		queue_frame(h, FINAL_POS + 1, -1);
		// frame ends one byte before the header is complete
		queue_frame(build_header(8'h04, 32'h4, 8'h04), FINAL_POS, -1);
		wait_drained();

		// lowest nonzero type limit
		write_type_limit(8'd1);
		queue_frame(build_header(8'h10, 32'h10, 8'h00), FINAL_POS + 1, -1);
		queue_frame(build_header(8'h11, 32'h11, 8'h01), FINAL_POS + 1, -1);
		random_frames(0, 1);
		wait_drained();

		// highest type limit
		write_type_limit(8'd255);
		queue_frame(build_header(8'h20, 32'h20, 8'hFE), FINAL_POS + 1, -1);
		queue_frame(build_header(8'h21, 32'h21, 8'hFF), FINAL_POS + 1, -1);
		wait_drained();

		// receiver holds off while short frames keep the results coming
		long_hold_req = 1'b1;
		repeat (30)
			queue_frame(build_header(8'($urandom), $urandom, 8'($urandom)),
				$urandom_range(1, 6), -1);
		queue_frame(build_header(8'h30, 32'h30, 8'h00), FINAL_POS + 1, -1);
		queue_frame(build_header(8'h31, 32'h31, 8'h00), FINAL_POS + 3, -1);
		wait_drained();

		write_type_limit(8'($urandom_range(2, 254)));
		random_frames(0, 1);
		wait_drained();

		// closing stretch at full rate on both sides
		idling_on = 1'b0;
		tx_odds   = 7'd0;
		write_type_limit(8'($urandom_range(1, 255)));
		random_frames(0, 1);
		wait_drained();

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

endmodule
